// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define MBE_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked property that also covers the reset cycles.
`define MBE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mbe_pkg.sv -----
`default_nettype none

package mbe_pkg;

  // Fixed-point format of coordinates and iterates
  localparam int FRAC_BITS = 28;
  localparam int IDX_W     = 10;
  localparam int CRD_W     = 32;
  localparam int CPROD_W   = CRD_W + IDX_W + 1;   // origin + index * step
  localparam int ZW        = CRD_W + 2;           // iterate u, v
  localparam int SQ_W      = 2 * CRD_W - FRAC_BITS; // u2, v2
  localparam int UVM_W     = FRAC_BITS + 1;       // |u|, |v| while still bounded
  localparam int UVP_W     = 2 * UVM_W;
  localparam int CNT_W     = 8;

  localparam logic [CNT_W-1:0] MAX_ITER = 8'd255;
  // Escape bound 4.0 in raw fixed point
  localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(4) << FRAC_BITS;

  // Worst-case beats held inside the block: two front stages, two queue
  // entries, one in the engine, one in the output register.
  localparam logic [2:0] MAX_INFLIGHT = 3'd6;

  typedef enum logic [1:0] {
    CFG_X_ORIGIN = 2'd0,
    CFG_Y_ORIGIN = 2'd1,
    CFG_X_STEP   = 2'd2,
    CFG_Y_STEP   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MULT,
    B_SQR
  } back_state_t;

  // One complex point c handed from front to back
  typedef struct packed {
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
  } c_point_t;

  localparam logic signed [CPROD_W-1:0] S32_MAX = CPROD_W'(64'sd2147483647);
  localparam logic signed [CPROD_W-1:0] S32_MIN = CPROD_W'(-64'sd2147483648);

  // Clamp a wide coordinate into the signed 32-bit range
  function automatic logic signed [CRD_W-1:0] sat32(input logic signed [CPROD_W-1:0] t);
    logic signed [CRD_W-1:0] r;
    if (t > S32_MAX) begin
      r = {1'b0, {(CRD_W-1){1'b1}}};
    end else if (t < S32_MIN) begin
      r = {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      r = $signed(t[CRD_W-1:0]);
    end
    return r;
  endfunction

  // Magnitude of an iterate
  function automatic logic [ZW-1:0] mag_z(input logic signed [ZW-1:0] a);
    logic [ZW-1:0] r;
    if (a[ZW-1]) begin
      r = ZW'(-a);
    end else begin
      r = ZW'(a);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mbe_front.sv -----
`default_nettype none

module mbe_front import mbe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [CRD_W-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [IDX_W-1:0]   in_column,
  input  wire logic [IDX_W-1:0]   in_row,
  output logic                    pt_valid,
  input  wire logic               pt_ready,
  output c_point_t                pt_data
);

  logic signed [CRD_W-1:0] x_origin_r, y_origin_r, x_step_r, y_step_r;

  logic                      a_v_r, a_v_nxt;
  logic signed [CPROD_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic                      b_v_r, b_v_nxt;
  c_point_t                  pt_r, pt_nxt;

  logic                      a_adv, b_adv;
  logic signed [IDX_W:0]     col_s, row_s;
  logic signed [CPROD_W-1:0] tx, ty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= '0;
      y_origin_r <= '0;
      x_step_r   <= '0;
      y_step_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_ORIGIN: x_origin_r <= $signed(cfg_wdata);
        CFG_Y_ORIGIN: y_origin_r <= $signed(cfg_wdata);
        CFG_X_STEP:   x_step_r   <= $signed(cfg_wdata);
        CFG_Y_STEP:   y_step_r   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Two-stage pipe: index * step, then add origin and clamp
  assign b_adv    = !b_v_r || pt_ready;
  assign a_adv    = !a_v_r || b_adv;
  assign in_ready = a_adv;

  assign col_s  = $signed({1'b0, in_column});
  assign row_s  = $signed({1'b0, in_row});
  assign px_nxt = col_s * x_step_r;
  assign py_nxt = row_s * y_step_r;

  assign tx = px_r + CPROD_W'(x_origin_r);
  assign ty = py_r + CPROD_W'(y_origin_r);

  always_comb begin
    a_v_nxt   = a_adv ? in_valid : a_v_r;
    b_v_nxt   = b_adv ? a_v_r : b_v_r;
    pt_nxt.cx = sat32(tx);
    pt_nxt.cy = sat32(ty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
    if (b_adv && a_v_r) begin
      pt_r <= pt_nxt;
    end
  end

  assign pt_valid = b_v_r;
  assign pt_data  = pt_r;

endmodule

`default_nettype wire

// ----- rtl/core/mbe_queue.sv -----
`default_nettype none

module mbe_queue import mbe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     s_valid,
  output logic          s_ready,
  input  wire c_point_t s_data,
  output logic          m_valid,
  input  wire logic     m_ready,
  output c_point_t      m_data
);

  c_point_t   q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;

  assign s_ready = (fill_r != 2'd2);
  assign m_valid = (fill_r != 2'd0);
  assign m_data  = q_mem_r[rd_ptr_r];

  assign push = s_valid && s_ready;
  assign pop  = m_valid && m_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= s_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mbe_back.sv -----
`default_nettype none

module mbe_back import mbe_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pt_valid,
  output logic                  pt_ready,
  input  wire c_point_t         pt_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [CNT_W-1:0]      out_iterations
);

  back_state_t state_r, state_nxt;

  logic signed [CRD_W-1:0] cx_r, cy_r;
  logic signed [ZW-1:0]    u_r, v_r, u_nxt, v_nxt;
  logic [SQ_W-1:0]         u2_r, v2_r, u2_nxt, v2_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [UVP_W-1:0]        puv_r, puv_nxt;
  logic                    neg_r, neg_nxt;
  logic [CNT_W-1:0]        res_r, res_nxt;
  logic                    res_v_r, res_v_nxt;

  logic                    ld_pt, ld_mult, ld_sqr, ld_res;
  logic [ZW-1:0]           mu, mv;
  logic [SQ_W:0]           mag2;
  logic                    fin;
  logic [ZW-1:0]           tv;
  logic signed [ZW-1:0]    v_new;
  logic [ZW-1:0]           mvn;
  logic [2*CRD_W-1:0]      sq_u, sq_v;

  // Escape test on the current iterate, or the iteration limit reached
  assign mag2 = {1'b0, u2_r} + {1'b0, v2_r};
  assign fin  = (mag2 >= ESC_LIMIT) || (cnt_r == MAX_ITER);

  // Multiply phase: |u|*|v| magnitude and the new real part
  assign mu      = mag_z(u_r);
  assign mv      = mag_z(v_r);
  assign puv_nxt = mu[UVM_W-1:0] * mv[UVM_W-1:0];
  assign neg_nxt = u_r[ZW-1] ^ v_r[ZW-1];
  assign u_nxt   = $signed({{(ZW-FRAC_BITS-2){1'b0}}, u2_r[FRAC_BITS+1:0]})
                 - $signed({{(ZW-FRAC_BITS-2){1'b0}}, v2_r[FRAC_BITS+1:0]})
                 + ZW'(cx_r);

  // Square phase: finish the imaginary part, square both
  assign tv      = ZW'(puv_r[UVP_W-1:FRAC_BITS-1]);
  assign v_new   = (neg_r ? -$signed(tv) : $signed(tv)) + ZW'(cy_r);
  assign v_nxt   = v_new;
  assign mvn     = mag_z(v_new);
  assign sq_u    = mu[CRD_W-1:0] * mu[CRD_W-1:0];
  assign sq_v    = mvn[CRD_W-1:0] * mvn[CRD_W-1:0];
  assign u2_nxt  = sq_u[2*CRD_W-1:FRAC_BITS];
  assign v2_nxt  = sq_v[2*CRD_W-1:FRAC_BITS];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pt_ready  = 1'b0;
    ld_pt     = 1'b0;
    ld_mult   = 1'b0;
    ld_sqr    = 1'b0;
    ld_res    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        pt_ready = 1'b1;
        if (pt_valid) begin
          ld_pt     = 1'b1;
          state_nxt = B_MULT;
        end
      end
      B_MULT: begin
        if (fin) begin
          if (!res_v_r || out_ready) begin
            ld_res    = 1'b1;
            state_nxt = B_IDLE;
          end
        end else begin
          ld_mult   = 1'b1;
          state_nxt = B_SQR;
        end
      end
      B_SQR: begin
        ld_sqr    = 1'b1;
        state_nxt = B_MULT;
      end
      default: state_nxt = B_IDLE;
    endcase
    cnt_nxt   = cnt_r + CNT_W'(1);
    res_nxt   = cnt_r;
    res_v_nxt = ld_res || (res_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ld_pt) begin
      cx_r  <= pt_data.cx;
      cy_r  <= pt_data.cy;
      u_r   <= '0;
      v_r   <= '0;
      u2_r  <= '0;
      v2_r  <= '0;
      cnt_r <= '0;
    end
    if (ld_mult) begin
      puv_r <= puv_nxt;
      neg_r <= neg_nxt;
      u_r   <= u_nxt;
    end
    if (ld_sqr) begin
      v_r   <= v_nxt;
      u2_r  <= u2_nxt;
      v2_r  <= v2_nxt;
      cnt_r <= cnt_nxt;
    end
    if (ld_res) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = res_v_r;
  assign out_iterations = res_r;

endmodule

`default_nettype wire

// ----- rtl/core/mandelbrot_escape_time_pixel_unit.sv -----
// Channel  Handshake             Payload
// cfg      cfg_we                cfg_index[1:0], cfg_wdata[31:0]
// in       in_valid / in_ready   in_column[9:0], in_row[9:0]
// out      out_valid / out_ready out_iterations[7:0]
//
// Front: forms c through an index * step stage, then an origin add and clamp stage.
// Back: each iteration runs a multiply phase, then a square phase, in one shared
//   engine; a final escape test and the idle state that takes the next point
//   follow, and a point is finished before the next is taken. Two beats queue
//   between front and back.
// Reset: synchronous, active low; config registers return to zero.
// Stalls: the front keeps accepting until the queue and both front stages
//   fill; out_ready low holds the engine only once a second result is ready.
`default_nettype none

module mandelbrot_escape_time_pixel_unit import mbe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [CRD_W-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [IDX_W-1:0]   in_column,
  input  wire logic [IDX_W-1:0]   in_row,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CNT_W-1:0]        out_iterations
);

  logic     f_valid, f_ready;
  c_point_t f_data;
  logic     q_valid, q_ready;
  c_point_t q_data;

  mbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_column (in_column),
    .in_row    (in_row),
    .pt_valid  (f_valid),
    .pt_ready  (f_ready),
    .pt_data   (f_data)
  );

  mbe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_data  (f_data),
    .m_valid (q_valid),
    .m_ready (q_ready),
    .m_data  (q_data)
  );

  mbe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pt_valid       (q_valid),
    .pt_ready       (q_ready),
    .pt_data        (q_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_iterations (out_iterations)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mbe_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module mbe_checker import mbe_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CNT_W-1:0] out_iterations
);

  logic [2:0] inflight_r, inflight_nxt;
  logic       in_beat, out_beat;

  // Beats accepted but not yet delivered
  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r + 3'(in_beat) - 3'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 3'd0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `MBE_ASSERT_RST(a_rst_out_idle, !rst_n |=> !out_valid, "out_valid set after reset")
  `MBE_ASSERT_RST(a_rst_in_ready, !rst_n |=> in_ready, "in_ready low after reset")
  `MBE_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_iterations), "result dropped or changed while stalled")
  `MBE_ASSERT_CLK(a_no_phantom, out_beat |-> inflight_r != 3'd0, "result with no item outstanding")
  `MBE_ASSERT_CLK(a_bounded, inflight_r <= MAX_INFLIGHT, "more beats held than storage allows")

endmodule

bind mandelbrot_escape_time_pixel_unit mbe_checker u_mbe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_iterations (out_iterations)
);

`default_nettype wire

// ----- test/tb_mandelbrot_escape_time_pixel_unit.sv -----
`default_nettype none

module tb_mandelbrot_escape_time_pixel_unit;
  import mbe_pkg::*;

  localparam int GAP_MAX    = 18;
  localparam int RND_PHASES = 10;
  localparam int PHASE_PIX  = 125;
  localparam int DRAIN_CYC  = 20;
  localparam longint ESCAPE_RAW = longint'(4) << FRAC_BITS;
  localparam logic [CNT_W-1:0] FIRST_PASS = 8'd1;

  // random register sets per phase
  localparam int VIEW_SET = 0;
  localparam int BITS_SET = 1;
  localparam int EDGE_SET = 2;
  localparam int ZOOM_SET = 3;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cfg_reg_t          idx;
    logic [CRD_W-1:0]  wdata;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  line;
    logic              typed;
    logic [CNT_W-1:0]  iter;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [CRD_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [IDX_W-1:0]  in_column = '0;
  logic [IDX_W-1:0]  in_row = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CNT_W-1:0]  out_iterations;

  // typed expectation riding along with the current input beat
  logic              pix_typed = 1'b0;
  logic [CNT_W-1:0]  pix_iter = '0;

  // local copy of the coordinate registers
  logic signed [CRD_W-1:0] x_org = '0;
  logic signed [CRD_W-1:0] y_org = '0;
  logic signed [CRD_W-1:0] x_stp = '0;
  logic signed [CRD_W-1:0] y_stp = '0;

  logic [CNT_W-1:0]  iter_due[$];
  logic [CNT_W-1:0]  due_iter;
  int                fail_cnt = 0;
  bit                in_calm = 1'b0;
  bit                out_calm = 1'b0;

  mandelbrot_escape_time_pixel_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_column      (in_column),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_iterations (out_iterations)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("tb: failure");
    $finish;
  end

  // origin + index * step, clamped to signed 32 bits
  function automatic longint clamp_coord(input logic signed [CRD_W-1:0] org,
                                         input logic signed [CRD_W-1:0] stp,
                                         input logic [IDX_W-1:0] idx);
    longint t;
    t = longint'(org) + longint'({1'b0, idx}) * longint'(stp);
    if (t > 64'sd2147483647) begin
      t = 64'sd2147483647;
    end else if (t < -64'sd2147483648) begin
      t = -64'sd2147483648;
    end
    return t;
  endfunction

  // fixed-point square, magnitude truncated
  function automatic longint fx_square(input longint a);
    bit [63:0] m;
    m = a[63] ? -a : a;
    return $signed((m * m) >> FRAC_BITS);
  endfunction

  // 2*a*b in fixed point, truncated toward zero, sign applied last
  function automatic longint fx_twice_prod(input longint a, input longint b);
    bit [63:0] ma;
    bit [63:0] mb;
    longint    r;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    r = $signed((ma * mb) >> (FRAC_BITS - 1));
    return (a[63] != b[63]) ? -r : r;
  endfunction

  // escape-time count for one pixel under the current registers
  function automatic logic [CNT_W-1:0] escape_count(input logic [IDX_W-1:0] col,
                                                    input logic [IDX_W-1:0] line);
    longint cx;
    longint cy;
    longint re;
    longint im;
    longint re2;
    longint im2;
    int     n;
    cx = clamp_coord(x_org, x_stp, col);
    cy = clamp_coord(y_org, y_stp, line);
    re = 0;
    im = 0;
    re2 = 0;
    im2 = 0;
    n = 0;
    while (re2 + im2 < ESCAPE_RAW && n < int'(MAX_ITER)) begin
      im = fx_twice_prod(re, im) + cy;
      re = re2 - im2 + cx;
      re2 = fx_square(re);
      im2 = fx_square(im);
      n++;
    end
    return CNT_W'(n);
  endfunction

  function automatic plan_row_t cfg_row(input cfg_reg_t idx, input logic [CRD_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.wdata = val;
    return r;
  endfunction

  function automatic plan_row_t pix_row(input logic [IDX_W-1:0] col,
                                        input logic [IDX_W-1:0] line,
                                        input logic typed, input logic [CNT_W-1:0] iter);
    plan_row_t r;
    r = '0;
    r.kind = ROW_PIX;
    r.col = col;
    r.line = line;
    r.typed = typed;
    r.iter = iter;
    return r;
  endfunction

  // one register write; cfg_we is low again when the task returns
  task automatic write_reg(input cfg_reg_t idx, input logic [CRD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_X_ORIGIN: x_org = val;
      CFG_Y_ORIGIN: y_org = val;
      CFG_X_STEP:   x_stp = val;
      CFG_Y_STEP:   y_stp = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every pending pixel to come out
  task automatic settle();
    in_valid <= 1'b0;
    while (iter_due.size() != 0) @(negedge clk);
  endtask

  // drive one pixel beat after a random gap; returns on a falling edge
  task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] line,
                            input logic typed, input logic [CNT_W-1:0] iter);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_column <= col;
    in_row <= line;
    pix_typed <= typed;
    pix_iter <= iter;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
  endtask

  // result sink with random stalls
  initial begin
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // check result beats, then record expectations for accepted pixels
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (iter_due.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual %0d",
                 $time, out_iterations);
        fail_cnt++;
      end else begin
        due_iter = iter_due.pop_front();
        if (out_iterations !== due_iter) begin
          $display("%0t: iterations mismatch: expected %0d, actual %0d",
                   $time, due_iter, out_iterations);
          fail_cnt++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      iter_due.push_back(pix_typed ? pix_iter : escape_count(in_column, in_row));
    end
  end

  initial begin
    plan_row_t        plan[$];
    plan_row_t        r;
    int               kind;
    logic [CRD_W-1:0] regv[4];

    // after reset every register is zero, so c = 0 never escapes
    plan.push_back(pix_row(10'd0, 10'd0, 1'b1, MAX_ITER));
    plan.push_back(pix_row(10'd1023, 10'd1023, 1'b1, MAX_ITER));
    plan.push_back(pix_row(10'h2AA, 10'h155, 1'b1, MAX_ITER));
    // real extremes escape on the first pass
    plan.push_back(cfg_row(CFG_X_ORIGIN, 32'h7FFF_FFFF));
    plan.push_back(pix_row(10'd0, 10'd0, 1'b1, FIRST_PASS));
    plan.push_back(cfg_row(CFG_X_ORIGIN, 32'h8000_0000));
    plan.push_back(pix_row(10'd0, 10'd0, 1'b1, FIRST_PASS));
    // c = -2 hits |z|^2 = 4 exactly, which already counts as escaped
    plan.push_back(cfg_row(CFG_X_ORIGIN, 32'hE000_0000));
    plan.push_back(pix_row(10'd0, 10'd0, 1'b1, FIRST_PASS));
    // real coordinate overflow clamps high, then low
    plan.push_back(cfg_row(CFG_X_ORIGIN, 32'h7FFF_FFFF));
    plan.push_back(cfg_row(CFG_X_STEP, 32'h7FFF_FFFF));
    plan.push_back(pix_row(10'd1023, 10'd0, 1'b1, FIRST_PASS));
    plan.push_back(cfg_row(CFG_X_ORIGIN, 32'h8000_0000));
    plan.push_back(cfg_row(CFG_X_STEP, 32'h8000_0000));
    plan.push_back(pix_row(10'd1023, 10'd1023, 1'b1, FIRST_PASS));
    // imaginary extremes, real part back at zero
    plan.push_back(cfg_row(CFG_X_ORIGIN, 32'h0));
    plan.push_back(cfg_row(CFG_X_STEP, 32'h0));
    plan.push_back(cfg_row(CFG_Y_ORIGIN, 32'h7FFF_FFFF));
    plan.push_back(pix_row(10'd0, 10'd0, 1'b1, FIRST_PASS));
    plan.push_back(cfg_row(CFG_Y_STEP, 32'h7FFF_FFFF));
    plan.push_back(pix_row(10'd0, 10'd1023, 1'b1, FIRST_PASS));
    plan.push_back(cfg_row(CFG_Y_ORIGIN, 32'h8000_0000));
    plan.push_back(cfg_row(CFG_Y_STEP, 32'h8000_0000));
    plan.push_back(pix_row(10'd1023, 10'd1023, 1'b1, FIRST_PASS));
    // c = 0.25 on the cusp, slow convergence
    plan.push_back(cfg_row(CFG_Y_ORIGIN, 32'h0));
    plan.push_back(cfg_row(CFG_Y_STEP, 32'h0));
    plan.push_back(cfg_row(CFG_X_ORIGIN, 32'h0400_0000));
    plan.push_back(pix_row(10'd512, 10'd512, 1'b0, '0));
    // whole-set view: 2.5/1024 per pixel from (-2, -1.25)
    plan.push_back(cfg_row(CFG_X_ORIGIN, 32'hE000_0000));
    plan.push_back(cfg_row(CFG_Y_ORIGIN, 32'hEC00_0000));
    plan.push_back(cfg_row(CFG_X_STEP, 32'h000A_0000));
    plan.push_back(cfg_row(CFG_Y_STEP, 32'h000A_0000));
    plan.push_back(pix_row(10'd0, 10'd0, 1'b0, '0));
    plan.push_back(pix_row(10'd819, 10'd512, 1'b0, '0));
    plan.push_back(pix_row(10'd512, 10'd512, 1'b0, '0));
    plan.push_back(pix_row(10'd1023, 10'd1023, 1'b0, '0));
    plan.push_back(pix_row(10'd700, 10'd600, 1'b0, '0));
    plan.push_back(pix_row(10'd300, 10'd700, 1'b0, '0));
    plan.push_back(pix_row(10'd600, 10'd100, 1'b0, '0));
    plan.push_back(pix_row(10'd410, 10'd512, 1'b0, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows; registers only change once the block is drained
    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_CFG) begin
        settle();
        write_reg(r.idx, r.wdata);
      end else begin
        send_pixel(r.col, r.line, r.typed, r.iter);
      end
    end

    // random phases, each with a fresh register set
    for (int ph = 0; ph < RND_PHASES; ph++) begin
      settle();
      if (ph == 3 || ph == 8) begin
        kind = BITS_SET;
      end else if (ph == 5) begin
        kind = EDGE_SET;
      end else begin
        kind = (ph % 2 == 0) ? VIEW_SET : ZOOM_SET;
      end
      for (int k = 0; k < 4; k++) begin
        case (kind)
          VIEW_SET: begin
            if (k == 0) regv[k] = $urandom_range(0, 805306368) - 671088640;
            else if (k == 1) regv[k] = $urandom_range(0, 671088640) - 402653184;
            else regv[k] = $urandom_range(0, 1572864) - 786432;
          end
          ZOOM_SET: begin
            if (k == 0) regv[k] = $urandom_range(0, 322122547) - 214748365;
            else if (k == 1) regv[k] = $urandom_range(0, 429496730) - 214748365;
            else regv[k] = $urandom_range(0, 8191) - 4096;
          end
          BITS_SET: regv[k] = $urandom;
          default: begin
            case ($urandom_range(0, 3))
              0: regv[k] = 32'h7FFF_FFFF;
              1: regv[k] = 32'h8000_0000;
              2: regv[k] = 32'h0;
              default: regv[k] = $urandom;
            endcase
          end
        endcase
        write_reg(cfg_reg_t'(k), regv[k]);
      end
      repeat (PHASE_PIX) begin
        send_pixel(IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)),
                   1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYC) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
